>>> sv/cll_pkg.sv
// cll_pkg: shared constants, types and codes for the cursor linked list core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cll_pkg;
  localparam int MAX_NODES  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int LINK_COUNT = MAX_NODES + 1;
  localparam int LW = $clog2(LINK_COUNT);
  localparam int SW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef logic [LW-1:0] link_t;

  typedef enum logic [2:0] {
    K_APPEND = 3'd0, K_DELETE = 3'd1, K_CLEAR = 3'd2,
    K_FWD = 3'd3, K_BACK = 3'd4, K_READ = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY_READ = 2'd1, ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE, S_EXEC, S_READ, S_RESP
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       exec;
    logic       resp;
  } cll_cmd_t;
endpackage
`default_nettype wire

>>> sv/cll_ctrl.sv
// cll_ctrl: request sequencer (load, execute, memory read, respond)
// depends on cll_pkg
`timescale 1ns / 1ps
`default_nettype none
module cll_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  output cll_pkg::cll_cmd_t cmd
);
  cll_pkg::fsm_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cll_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      cll_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = cll_pkg::S_EXEC;
        end
      end
      cll_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = cll_pkg::S_READ;
      end
      // value memory read at the updated cursor
      cll_pkg::S_READ: begin
        state_nxt = cll_pkg::S_RESP;
      end
      cll_pkg::S_RESP: begin
        cmd.resp = 1'b1;
        state_nxt = cll_pkg::S_IDLE;
      end
      default: state_nxt = cll_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("exec did not follow load");
  a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> ##1 cmd.resp) else $error("resp did not follow exec");
  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.resp})) else $error("command overlap");
`endif
endmodule
`default_nettype wire

>>> sv/cll_dp.sv
// cll_dp: link registers, value memory, cursor and count
// depends on cll_pkg
`timescale 1ns / 1ps
`default_nettype none
module cll_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cll_pkg::cll_cmd_t cmd,
  input  wire logic [2:0]        in_kind,
  input  wire logic signed [31:0] in_value,
  output logic                   out_valid,
  output logic signed [31:0]     out_current_value,
  output logic                   out_has_current,
  output logic                   out_vacant,
  output logic                   out_is_full,
  output logic [1:0]             out_status
);
  localparam int LC = cll_pkg::LINK_COUNT;
  localparam int MN = cll_pkg::MAX_NODES;
  localparam int DW = cll_pkg::DATA_WIDTH;
  localparam int LW = cll_pkg::LW;
  localparam int SW = cll_pkg::SW;
  localparam int CW = cll_pkg::CW;

  cll_pkg::link_t next_r [LC];
  cll_pkg::link_t prev_r [LC];
  logic [MN-1:0]  used_r;
  cll_pkg::link_t cur_r;
  logic [CW-1:0]  cnt_r;
  logic [2:0]     kind_r;
  logic [DW-1:0]  val_r;
  logic [1:0]     stat_r;
  logic [DW-1:0]  mem [MN];
  logic [DW-1:0]  rd_r;

  // lowest free slot
  logic [SW-1:0] free_s;
  always_comb begin
    free_s = '0;
    for (int i = MN - 1; i >= 0; i--) if (!used_r[i]) free_s = SW'(i);
  end

  logic           full;
  cll_pkg::link_t new_n, tail, c_p, c_n, fwd, bck;
  assign full  = (cnt_r >= CW'(MN));
  assign new_n = LW'(free_s) + LW'(1);
  assign tail  = prev_r[0];
  assign c_p   = prev_r[cur_r];
  assign c_n   = next_r[cur_r];
  assign fwd   = (c_n == '0) ? next_r[0] : c_n;
  assign bck   = (c_p == '0) ? prev_r[0] : c_p;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      val_r  <= DW'(in_value);
    end
  end

  // list update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LC; i++) begin
        next_r[i] <= '0;
        prev_r[i] <= '0;
      end
      used_r <= '0;
      cur_r  <= '0;
      cnt_r  <= '0;
      stat_r <= cll_pkg::ST_OK;
    end else if (cmd.exec) begin
      stat_r <= cll_pkg::ST_OK;
      case (kind_r)
        cll_pkg::K_APPEND: begin
          if (full) stat_r <= cll_pkg::ST_FULL;
          else begin
            used_r[free_s] <= 1'b1;
            next_r[new_n]  <= '0;
            prev_r[new_n]  <= tail;
            next_r[tail]   <= new_n;
            prev_r[0]      <= new_n;
            cur_r          <= new_n;
            cnt_r          <= cnt_r + CW'(1);
          end
        end
        cll_pkg::K_DELETE: begin
          if (cnt_r != '0 && cur_r != '0) begin
            next_r[c_p] <= c_n;
            prev_r[c_n] <= c_p;
            used_r[SW'(cur_r - LW'(1))] <= 1'b0;
            cnt_r <= cnt_r - CW'(1);
            // head after unlink
            cur_r <= (c_p == '0) ? c_n : next_r[0];
          end
        end
        cll_pkg::K_CLEAR: begin
          for (int i = 0; i < LC; i++) begin
            next_r[i] <= '0;
            prev_r[i] <= '0;
          end
          used_r <= '0;
          cur_r  <= '0;
          cnt_r  <= '0;
        end
        cll_pkg::K_FWD:  cur_r <= fwd;
        cll_pkg::K_BACK: cur_r <= bck;
        cll_pkg::K_READ: if (cur_r == '0) stat_r <= cll_pkg::ST_EMPTY_READ;
        default: ;
      endcase
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (cmd.exec && kind_r == cll_pkg::K_APPEND && !full) mem[free_s] <= val_r;
  end

  logic [SW-1:0] rd_a;
  assign rd_a = SW'(cur_r - LW'(1));
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_a];
  end

  // result word
  logic [31:0] cv;
  always_comb begin
    cv = '0;
    cv[DW-1:0] = rd_r;
  end
  assign out_valid         = cmd.resp;
  assign out_current_value = (cur_r != '0) ? $signed(cv) : 32'sd0;
  assign out_has_current   = (cur_r != '0);
  assign out_vacant        = (cnt_r == '0);
  assign out_is_full       = full;
  assign out_status        = stat_r;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MN)) else $error("count overflow");
  a_cnt_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(cnt_r)) else $error("count and slots disagree");
  a_empty_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (cur_r == '0)) else $error("cursor off sentinel on empty");
`endif
endmodule
`default_nettype wire

>>> sv/cursor_linked_list_core.sv
// cursor_linked_list_core: top level of the cursor linked list
// depends on cll_pkg, cll_ctrl, cll_dp
//
// usage:
//   raise start with in_kind and in_value while busy is low; the word is
//   taken at that edge. kinds: append, delete at cursor, clear, step
//   forward, step back, read.
//   the result word appears on the out_ ports for one cycle with
//   out_valid high, after the execute, memory read and respond states
//   that follow the accept edge. a new request is taken in the cycle
//   after that; busy stays high until then, so no request is taken
//   before the last result is shown. the memory read state comes from
//   the registered read of the value memory after the link update.
//   reset (rst_n low, synchronous) empties the list and parks the cursor
//   on the sentinel; value slots stay undefined until appended.
//   status: ok, read of empty list, or append refused when full.
`timescale 1ns / 1ps
`default_nettype none
module cursor_linked_list_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_kind,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  output logic signed [31:0]      out_current_value,
  output logic                    out_has_current,
  output logic                    out_vacant,
  output logic                    out_is_full,
  output logic [1:0]              out_status
);
  cll_pkg::cll_cmd_t cmd;

  cll_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd));

  cll_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_kind(in_kind), .in_value(in_value),
    .out_valid(out_valid), .out_current_value(out_current_value),
    .out_has_current(out_has_current), .out_vacant(out_vacant),
    .out_is_full(out_is_full), .out_status(out_status)
  );
endmodule
`default_nettype wire

>>> tb/sv/cursor_linked_list_core_tb.sv
// cursor_linked_list_core_tb: self-checking bench for the cursor linked list core
// depends on cll_pkg and cursor_linked_list_core; keeps its own list model
`timescale 1ns / 1ps
`default_nettype none
module cursor_linked_list_core_tb;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic signed [31:0] cur_value;
    logic               has_cur;
    logic               empty;
    logic               full;
    cll_pkg::status_t   status;
  } list_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_kind = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic signed [31:0] out_current_value;
  logic               out_has_current;
  logic               out_vacant;
  logic               out_is_full;
  logic [1:0]         out_status;

  // list model state
  logic [31:0]     slot_val [cll_pkg::MAX_NODES];
  cll_pkg::link_t  fwd_link [cll_pkg::LINK_COUNT];
  cll_pkg::link_t  back_link [cll_pkg::LINK_COUNT];
  logic            slot_busy [cll_pkg::MAX_NODES];
  cll_pkg::link_t  cur_node;
  int              elem_count;

  list_word_t pending_words[$];
  int  mismatch_count = 0;
  int  words_sent = 0;
  int  words_seen = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;
  int  full_refusals = 0;
  int  empty_reads = 0;

  cursor_linked_list_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_value(in_value),
    .out_valid(out_valid), .out_current_value(out_current_value),
    .out_has_current(out_has_current), .out_vacant(out_vacant),
    .out_is_full(out_is_full), .out_status(out_status)
  );

  always #1 clk = ~clk;

  // empty the model list
  function automatic void model_clear();
    for (int i = 0; i < cll_pkg::LINK_COUNT; i++) begin
      fwd_link[i] = '0;
      back_link[i] = '0;
    end
    for (int i = 0; i < cll_pkg::MAX_NODES; i++) slot_busy[i] = 1'b0;
    cur_node = '0;
    elem_count = 0;
  endfunction

  // apply one request to the model and return the expected word
  function automatic list_word_t apply_request(logic [2:0] kind, logic [31:0] val);
    list_word_t w;
    cll_pkg::status_t st;
    int slot;
    cll_pkg::link_t n, tail, p, nx;
    st = cll_pkg::ST_OK;
    slot = -1;
    case (kind)
      cll_pkg::K_APPEND: begin
        if (elem_count < cll_pkg::MAX_NODES)
          for (int s = cll_pkg::MAX_NODES - 1; s >= 0; s--) if (!slot_busy[s]) slot = s;
        if (slot < 0) begin
          st = cll_pkg::ST_FULL;
        end else begin
          n = cll_pkg::link_t'(slot + 1);
          tail = back_link[0];
          slot_val[slot] = val;
          slot_busy[slot] = 1'b1;
          fwd_link[n] = '0;
          back_link[n] = tail;
          fwd_link[tail] = n;
          back_link[0] = n;
          cur_node = n;
          elem_count++;
        end
      end
      cll_pkg::K_DELETE: begin
        if (elem_count != 0 && cur_node != 0) begin
          p = back_link[cur_node];
          nx = fwd_link[cur_node];
          fwd_link[p] = nx;
          back_link[nx] = p;
          slot_busy[cur_node - 1] = 1'b0;
          elem_count--;
          cur_node = fwd_link[0];
        end
      end
      cll_pkg::K_CLEAR: model_clear();
      cll_pkg::K_FWD: begin
        cur_node = fwd_link[cur_node];
        if (cur_node == 0) cur_node = fwd_link[0];
      end
      cll_pkg::K_BACK: begin
        cur_node = back_link[cur_node];
        if (cur_node == 0) cur_node = back_link[0];
      end
      cll_pkg::K_READ: begin
        if (cur_node == 0) st = cll_pkg::ST_EMPTY_READ;
      end
      default: ;
    endcase
    w.cur_value = (cur_node != 0) ? slot_val[cur_node - 1] : '0;
    w.has_cur = (cur_node != 0);
    w.empty = (elem_count == 0);
    w.full = (elem_count >= cll_pkg::MAX_NODES);
    w.status = st;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] word %0d: %s got %h want %h", $time, words_seen, what, got, want);
    mismatch_count++;
  endtask

  // send one request word, with a random gap before it when gaps_on is set
  task automatic send_word(logic [2:0] kind, logic signed [31:0] val);
    list_word_t w;
    while (gaps_on && $urandom_range(99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    w = apply_request(kind, val);
    if (w.status == cll_pkg::ST_FULL) full_refusals++;
    if (w.status == cll_pkg::ST_EMPTY_READ) empty_reads++;
    pending_words.push_back(w);
    words_sent++;
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    list_word_t w;
    if (rst_n && out_valid) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_current_value, '0);
      end else begin
        w = pending_words.pop_front();
        if (out_current_value !== w.cur_value)
          report_mismatch("current_value", out_current_value, w.cur_value);
        if (out_has_current !== w.has_cur)
          report_mismatch("has_current", out_has_current, w.has_cur);
        if (out_vacant !== w.empty) report_mismatch("vacant", out_vacant, w.empty);
        if (out_is_full !== w.full) report_mismatch("is_full", out_is_full, w.full);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
      end
    end
  end

  // watchdog: cycles without any accepted word or result word
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // requests on the empty list, fills to full, refused append, walks both ways over the wrap
  task automatic test_fill_and_walk();
    send_word(cll_pkg::K_READ, 32'sd0);
    send_word(cll_pkg::K_DELETE, 32'sd0);
    send_word(cll_pkg::K_FWD, 32'sd0);
    send_word(cll_pkg::K_BACK, 32'sd0);
    send_word(cll_pkg::K_APPEND, 32'h7fffffff);
    send_word(cll_pkg::K_APPEND, 32'h80000000);
    send_word(cll_pkg::K_APPEND, 32'hffffffff);
    send_word(cll_pkg::K_APPEND, 32'h00000000);
    for (int i = 0; i < cll_pkg::MAX_NODES - 4; i++) send_word(cll_pkg::K_APPEND, $urandom);
    send_word(cll_pkg::K_APPEND, 32'h12345678);
    send_word(cll_pkg::K_FWD, 32'sd0);
    send_word(cll_pkg::K_BACK, 32'sd0);
    send_word(cll_pkg::K_READ, 32'sd0);
  endtask

  // deletes, reuse of lowest slot, unused kinds and clear
  task automatic test_delete_and_clear();
    send_word(cll_pkg::K_DELETE, 32'sd0);
    send_word(cll_pkg::K_FWD, 32'sd0);
    send_word(cll_pkg::K_DELETE, 32'sd0);
    send_word(cll_pkg::K_APPEND, 32'h5a5a5a5a);
    send_word(3'd6, 32'sd0);
    send_word(3'd7, 32'sd0);
    send_word(cll_pkg::K_CLEAR, 32'sd0);
    send_word(cll_pkg::K_READ, 32'sd0);
    send_word(cll_pkg::K_APPEND, 32'h0000abcd);
  endtask

  // random requests, biased so the list moves between empty and full
  task automatic test_random_traffic(int count);
    logic [2:0] k;
    int r;
    for (int i = 0; i < count; i++) begin
      gaps_on = !(i >= count / 3 && i < count / 2);
      r = $urandom_range(99);
      if (r < 2) k = cll_pkg::K_CLEAR;
      else if (r < 4) k = 3'($urandom_range(7, 6));
      else if (r < 4 + (elem_count < 8 ? 40 : 22)) k = cll_pkg::K_APPEND;
      else if (r < 62) k = cll_pkg::K_DELETE;
      else if (r < 74) k = cll_pkg::K_FWD;
      else if (r < 86) k = cll_pkg::K_BACK;
      else k = cll_pkg::K_READ;
      send_word(k, $urandom);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    model_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_and_walk();
    test_delete_and_clear();
    test_random_traffic(1570);
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d request words, checked %0d result words", words_sent, words_seen);
    $display("covered %0d full refusals and %0d empty reads", full_refusals, empty_reads);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

>>> cursor_linked_list_core.f
sv/cll_pkg.sv
sv/cll_ctrl.sv
sv/cll_dp.sv
sv/cursor_linked_list_core.sv
tb/sv/cursor_linked_list_core_tb.sv
